[hdl/bsrq_pkg.sv]
package bsrq_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int RATIO_BITS     = 24;
  localparam int TW             = 31;  // time width, Q15.16 unsigned
  localparam int SW             = 32;  // s width, Q16.16 signed
  localparam int MW             = 33;  // multiplier operand width
  localparam int PW             = 2 * MW;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] KIND_FOLLOW   = 3'd2;
  localparam logic [2:0] KIND_OVERTAKE = 3'd3;
  localparam logic [2:0] KIND_OTHER    = 3'd4;

  localparam logic CFG_S_LIMIT = 1'b0;
  localparam logic CFG_KIND    = 1'b1;

  typedef struct packed {
    logic [1:0]           operation;
    logic [TW-1:0]        point_time;
    logic signed [SW-1:0] lower_s_in;
    logic signed [SW-1:0] upper_s_in;
    logic signed [SW-1:0] query_s;
  } in_t;

  typedef struct packed {
    logic                 load_full;
    logic                 range_valid;
    logic signed [SW-1:0] range_upper;
    logic signed [SW-1:0] range_lower;
    logic                 unblock_valid;
    logic signed [SW-1:0] unblock_upper;
    logic signed [SW-1:0] unblock_lower;
    logic                 inside_res;
  } out_t;

endpackage

[hdl/bsrq_ram.sv]
module bsrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/bsrq_div.sv]
module bsrq_div import bsrq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TW-1:0]         num,
  input  logic [TW-1:0]         den,
  output logic                  done,
  output logic [RATIO_BITS-1:0] q
);

  // restoring divide, one quotient bit a cycle; caller ensures num < den
  localparam int CNTW = $clog2(RATIO_BITS);

  logic [TW-1:0]         rem_r;
  logic [TW-1:0]         den_r;
  logic [RATIO_BITS-1:0] q_r;
  logic [CNTW-1:0]       cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic [TW:0]           shifted;
  logic                  ge;

  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && !start && (cnt_r == '0);
      if (start) begin
        rem_r <= num;
        den_r <= den;
        q_r   <= '0;
        cnt_r <= CNTW'(RATIO_BITS - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        // remainder stays below den, so it fits TW bits
        rem_r <= TW'(ge ? (shifted - {1'b0, den_r}) : shifted);
        q_r   <= {q_r[RATIO_BITS-2:0], ge};
        if (cnt_r == '0) begin
          run_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

[hdl/bsrq_mul.sv]
module bsrq_mul import bsrq_pkg::*; (
  input  logic                 clk,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [PW-1:0] p
);

  logic signed [PW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

[hdl/st_boundary_range_query.sv]
// Space-time boundary lookup: table of (time, lower s, upper s); time Q15.16, s Q16.16.
// Clear, append and unused words: result one cycle after accept, busy stays low.
// Query: busy in S_RMIN, S_RMAX, S_CHK, S_SRCH/S_SCMP for k search probes (k <= 7 at 64 points),
//   S_RL, S_RR, S_DIVS, S_DIV when the ratio needs the bit-serial divider, and S_MUL; result word
//   in the next cycle, when a new word can be taken. Empty table: busy stays low; time outside the
//   span: busy ends after S_CHK. Results strobe one cycle on out_valid, no stall; sync active-low
//   reset clears point count and sequencer and puts the config registers back to their defaults.
module st_boundary_range_query import bsrq_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_t           in_data,
  output logic          out_valid,
  output out_t          out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [TW-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = TW + 2 * SW;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RMIN = 11'b000_0000_0010,
    S_RMAX = 11'b000_0000_0100,
    S_CHK  = 11'b000_0000_1000,
    S_SRCH = 11'b000_0001_0000,
    S_SCMP = 11'b000_0010_0000,
    S_RL   = 11'b000_0100_0000,
    S_RR   = 11'b000_1000_0000,
    S_DIVS = 11'b001_0000_0000,
    S_DIV  = 11'b010_0000_0000,
    S_MUL  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic [TW-1:0] s_limit_r;
  logic [2:0]    kind_r;

  // item and table state
  in_t           in_r;
  logic [CW-1:0] count_r;
  logic [TW-1:0] tmin_r, tmax_r, tl_r, tr_r;
  logic [CW-1:0] first_r, cnt_r;
  logic [AW-1:0] li_r, ri_r;
  logic signed [SW-1:0] ul_r, ll_r, ur_r, lr_r;
  logic [RATIO_BITS:0]  r_r;
  logic [2:0]           mstep_r;
  logic signed [SW-1:0] up_c_r, lo_c_r;
  logic signed [PW-1:0] pa_r;
  logic                 cu_pos_r, cu_neg_r;

  logic out_valid_r;
  out_t out_data_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // table RAM: {time, lower, upper}
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic [TW-1:0] rd_time;
  logic signed [SW-1:0] rd_lower, rd_upper;
  logic          full;

  assign full   = (count_r >= CW'(MAX_POINTS));
  assign ram_we = accept && (in_data.operation == OP_APPEND) && !full;
  assign rd_time  = ram_rdata[EW-1 -: TW];
  assign rd_lower = ram_rdata[2*SW-1 -: SW];
  assign rd_upper = ram_rdata[SW-1:0];

  logic [CW-1:0] step;
  logic [CW-1:0] cm1;
  logic [CW-1:0] probe;
  assign step  = cnt_r >> 1;
  assign cm1   = count_r - 1'b1;
  assign probe = first_r + step;

  always_comb begin
    unique case (state_r)
      S_RMAX:  ram_raddr = cm1[AW-1:0];
      S_SRCH:  ram_raddr = probe[AW-1:0];
      S_RL:    ram_raddr = li_r;
      S_RR:    ram_raddr = ri_r;
      default: ram_raddr = '0;
    endcase
  end

  bsrq_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_data.point_time, in_data.lower_s_in, in_data.upper_s_in}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ratio divider
  logic                  div_start, div_done, ratio_ok, ratio_one;
  logic [TW-1:0]         div_num, div_den;
  logic [RATIO_BITS-1:0] div_q;

  assign div_num   = in_r.point_time - tl_r;
  assign div_den   = rd_time - tl_r;
  assign ratio_ok  = (rd_time > tl_r) && (in_r.point_time > tl_r);
  assign ratio_one = div_num >= div_den;
  assign div_start = (state_r == S_DIVS) && ratio_ok && !ratio_one;

  bsrq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // shared multiplier; operand pair picked by mstep
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [MW-1:0] dta, dtb, dsau, dsbu, dsal, dsbl;
  logic signed [PW-1:0] p_sh;

  assign dta  = MW'({2'b00, tl_r}) - MW'({2'b00, in_r.point_time});
  assign dtb  = MW'({2'b00, tr_r}) - MW'({2'b00, in_r.point_time});
  assign dsau = {ul_r[SW-1], ul_r} - {in_r.query_s[SW-1], in_r.query_s};
  assign dsbu = {ur_r[SW-1], ur_r} - {in_r.query_s[SW-1], in_r.query_s};
  assign dsal = {ll_r[SW-1], ll_r} - {in_r.query_s[SW-1], in_r.query_s};
  assign dsbl = {lr_r[SW-1], lr_r} - {in_r.query_s[SW-1], in_r.query_s};

  always_comb begin
    case (mstep_r)
      3'd0:    begin mul_a = {ur_r[SW-1], ur_r} - {ul_r[SW-1], ul_r};
                     mul_b = MW'(r_r); end
      3'd1:    begin mul_a = {lr_r[SW-1], lr_r} - {ll_r[SW-1], ll_r};
                     mul_b = MW'(r_r); end
      3'd2:    begin mul_a = dta;  mul_b = dsbu; end
      3'd3:    begin mul_a = dsau; mul_b = dtb;  end
      3'd4:    begin mul_a = dta;  mul_b = dsbl; end
      default: begin mul_a = dsal; mul_b = dtb;  end
    endcase
  end

  bsrq_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign p_sh = mul_p >>> RATIO_BITS;  // floor of product / 2^24

  // result formatting
  logic signed [SW-1:0] slim;
  logic                 cl_pos, cl_neg, in_band;
  out_t                 res_span, res_query, res_nxt;
  logic                 emit;

  assign slim    = {1'b0, s_limit_r};
  assign cl_pos  = pa_r > mul_p;
  assign cl_neg  = pa_r < mul_p;
  assign in_band = (in_r.point_time > tmin_r) && (in_r.point_time < tmax_r) &&
                   ((cu_pos_r && cl_neg) || (cu_neg_r && cl_pos));

  always_comb begin
    res_span               = '0;
    res_span.unblock_valid = 1'b1;
    res_span.unblock_upper = slim;

    res_query               = '0;
    res_query.range_valid   = 1'b1;
    res_query.range_upper   = (up_c_r < slim) ? up_c_r : slim;
    res_query.range_lower   = (lo_c_r > 0) ? lo_c_r : '0;
    res_query.unblock_valid = 1'b1;
    res_query.unblock_upper = slim;
    res_query.inside_res    = in_band;
    if (kind_r <= KIND_FOLLOW) begin
      res_query.unblock_upper = lo_c_r;
    end else if (kind_r == KIND_OVERTAKE) begin
      res_query.unblock_lower = (up_c_r > 0) ? up_c_r : '0;
    end else begin
      res_query.unblock_valid = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    res_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_QUERY) begin
            if (count_r == '0) begin
              emit    = 1'b1;
              res_nxt = res_span;
            end else begin
              state_nxt = S_RMIN;
            end
          end else begin
            emit              = 1'b1;
            res_nxt.load_full = (in_data.operation == OP_APPEND) && full;
          end
        end
      end
      S_RMIN: state_nxt = S_RMAX;
      S_RMAX: state_nxt = S_CHK;
      S_CHK: begin
        if (in_r.point_time >= tmin_r && in_r.point_time <= rd_time) begin
          state_nxt = S_SRCH;
        end else begin
          emit      = 1'b1;
          res_nxt   = res_span;
          state_nxt = S_IDLE;
        end
      end
      S_SRCH: state_nxt = (cnt_r == '0) ? S_RL : S_SCMP;
      S_SCMP: state_nxt = S_SRCH;
      S_RL:   state_nxt = S_RR;
      S_RR:   state_nxt = S_DIVS;
      S_DIVS: state_nxt = div_start ? S_DIV : S_MUL;
      S_DIV:  state_nxt = div_done ? S_MUL : S_DIV;
      S_MUL: begin
        if (mstep_r == 3'd6) begin
          emit      = 1'b1;
          res_nxt   = res_query;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      s_limit_r   <= '1;
      kind_r      <= KIND_OTHER;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (emit) begin
        out_data_r <= res_nxt;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_S_LIMIT: s_limit_r <= cfg_wdata;
          CFG_KIND:    kind_r    <= cfg_wdata[2:0];
          default:     ;
        endcase
      end

      if (accept) begin
        in_r <= in_data;
        if (in_data.operation == OP_CLEAR) begin
          count_r <= '0;
        end else if (ram_we) begin
          count_r <= count_r + 1'b1;
        end
      end

      unique case (state_r)
        S_RMAX: tmin_r <= rd_time;
        S_CHK: begin
          tmax_r  <= rd_time;
          first_r <= '0;
          cnt_r   <= count_r;
        end
        S_SRCH: begin
          // lower bound found: pick the bracketing pair
          if (first_r == '0) begin
            li_r <= '0;
            ri_r <= '0;
          end else if (first_r >= count_r) begin
            li_r <= cm1[AW-1:0];
            ri_r <= cm1[AW-1:0];
          end else begin
            li_r <= AW'(first_r - 1'b1);
            ri_r <= first_r[AW-1:0];
          end
        end
        S_SCMP: begin
          if (rd_time < in_r.point_time) begin
            first_r <= probe + 1'b1;
            cnt_r   <= cnt_r - step - 1'b1;
          end else begin
            cnt_r <= step;
          end
        end
        S_DIVS: begin
          tr_r    <= rd_time;
          ur_r    <= rd_upper;
          lr_r    <= rd_lower;
          mstep_r <= '0;
          if (!ratio_ok) begin
            r_r <= '0;
          end else if (ratio_one) begin
            r_r <= (RATIO_BITS+1)'(1) << RATIO_BITS;
          end
        end
        S_DIV: begin
          if (div_done) begin
            r_r <= {1'b0, div_q};
          end
        end
        S_MUL: begin
          mstep_r <= mstep_r + 1'b1;
          case (mstep_r)
            3'd1: up_c_r <= ul_r + p_sh[SW-1:0];
            3'd2: lo_c_r <= ll_r + p_sh[SW-1:0];
            3'd3: pa_r   <= mul_p;
            3'd4: begin
              cu_pos_r <= pa_r > mul_p;
              cu_neg_r <= pa_r < mul_p;
            end
            3'd5: pa_r   <= mul_p;
            default: ;
          endcase
        end
        default: ;
      endcase

      // left entry arrives in the cycle after its read is issued
      if (state_r == S_RR) begin
        tl_r <= rd_time;
        ul_r <= rd_upper;
        ll_r <= rd_lower;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bsrq_pkg::*;

  localparam int TBL_DEPTH  = MAX_POINTS_DEF;
  localparam int N_PHASES   = 8;
  localparam int PHASE_WORDS = 125;    // at least 1000 words over all phases
  localparam int STALL_LIMIT = 4000;   // cycles with no accept and no result before giving up

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [TW-1:0] cfg_wdata;

  st_boundary_range_query DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the band table (updated at accept time) and config (updated on cfg_we)
  // ---------------------------------------------------------------------------
  logic [TW-1:0]        band_t  [TBL_DEPTH];
  logic signed [SW-1:0] band_lo [TBL_DEPTH];
  logic signed [SW-1:0] band_up [TBL_DEPTH];
  int                   band_cnt;
  logic [TW-1:0]        s_lim;
  logic [2:0]           kind;

  in_t  word_q[$];       // words waiting for the driver
  out_t band_exp_q[$];   // predicted results, oldest first

  int  sender_idle_pct;
  bit  accepted_last;    // word taken at the most recent rising edge
  int  stall_cnt;
  int  mismatches;

  // first index whose time is not below t (fixed halving search)
  function automatic int band_search(logic [TW-1:0] t);
    int first, cnt, stp;
    first = 0;
    cnt = band_cnt;
    while (cnt > 0) begin
      stp = cnt / 2;
      if (band_t[first + stp] < t) begin
        first += stp + 1;
        cnt -= stp + 1;
      end else begin
        cnt = stp;
      end
    end
    return first;
  endfunction

  // a + floor((b - a) * r / 2^24)
  function automatic longint band_lerp(longint a, longint b, longint r);
    longint p;
    p = (b - a) * r;
    if (p >= 0) return a + (p >>> RATIO_BITS);
    return a - (((-p) + ((64'sd1 <<< RATIO_BITS) - 1)) >>> RATIO_BITS);
  endfunction

  function automatic int cross_sgn(longint tp, longint sp, longint ta, longint sa,
                                   longint tb, longint sb);
    longint x, y;
    x = (ta - tp) * (sb - sp);
    y = (sa - sp) * (tb - tp);
    return (x > y) ? 1 : ((x < y) ? -1 : 0);
  endfunction

  // apply one accepted word to the shadow table and return its result
  function automatic out_t band_predict(in_t w);
    out_t   res;
    int     idx, lft, rgt, cu, cl;
    longint t, r, up_c, lo_c, num, den, tmin, tmax;
    res = '0;
    t = longint'(w.point_time);
    case (w.operation)
      OP_CLEAR: band_cnt = 0;
      OP_APPEND: begin
        if (band_cnt >= TBL_DEPTH) begin
          res.load_full = 1'b1;
        end else begin
          band_t[band_cnt]  = w.point_time;
          band_lo[band_cnt] = w.lower_s_in;
          band_up[band_cnt] = w.upper_s_in;
          band_cnt++;
        end
      end
      OP_QUERY: begin
        res.unblock_valid = 1'b1;
        res.unblock_upper = SW'(longint'(s_lim));
        if (band_cnt > 0) begin
          tmin = longint'(band_t[0]);
          tmax = longint'(band_t[band_cnt-1]);
          if (t >= tmin && t <= tmax) begin
            idx = band_search(w.point_time);
            if (idx == 0) begin
              lft = 0; rgt = 0;
            end else if (idx >= band_cnt) begin
              lft = band_cnt - 1; rgt = band_cnt - 1;
            end else begin
              lft = idx - 1; rgt = idx;
            end
            r = 0;
            // equal neighbor times give ratio 0 instead of 0/0
            if (band_t[rgt] > band_t[lft] && t > longint'(band_t[lft])) begin
              num = t - longint'(band_t[lft]);
              den = longint'(band_t[rgt]) - longint'(band_t[lft]);
              if (num >= den) r = 64'sd1 <<< RATIO_BITS;
              else r = (num <<< RATIO_BITS) / den;
            end
            up_c = band_lerp(longint'(band_up[lft]), longint'(band_up[rgt]), r);
            lo_c = band_lerp(longint'(band_lo[lft]), longint'(band_lo[rgt]), r);
            res.range_valid = 1'b1;
            res.range_upper = SW'((up_c < longint'(s_lim)) ? up_c : longint'(s_lim));
            res.range_lower = SW'((lo_c > 0) ? lo_c : 64'sd0);
            if (kind <= KIND_FOLLOW) res.unblock_upper = SW'(lo_c);
            else if (kind == KIND_OVERTAKE) res.unblock_lower = SW'((up_c > 0) ? up_c : 64'sd0);
            else res.unblock_valid = 1'b0;
            if (t > tmin && t < tmax) begin
              cu = cross_sgn(t, longint'(w.query_s), longint'(band_t[lft]),
                             longint'(band_up[lft]), longint'(band_t[rgt]),
                             longint'(band_up[rgt]));
              cl = cross_sgn(t, longint'(w.query_s), longint'(band_t[lft]),
                             longint'(band_lo[lft]), longint'(band_t[rgt]),
                             longint'(band_lo[rgt]));
              res.inside_res = (cu * cl < 0);
            end
          end
        end
      end
      default: ;  // unused op: nothing changes, all zero
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || accepted_last) begin
      // previous word gone (or none out): offer the next one, maybe idle
      if (word_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        start   <= 1'b1;
        in_data <= word_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples on the rising edge, predicts accepts, checks results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    bit   took, got_word;
    took     = 1'b0;
    got_word = rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        took = 1'b1;
        if (band_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", out_data);
        end else begin
          want = band_exp_q.pop_front();
          if (out_data.load_full !== want.load_full ||
              out_data.range_valid !== want.range_valid ||
              out_data.range_upper !== want.range_upper ||
              out_data.range_lower !== want.range_lower ||
              out_data.unblock_valid !== want.unblock_valid ||
              out_data.unblock_upper !== want.unblock_upper ||
              out_data.unblock_lower !== want.unblock_lower ||
              out_data.inside_res !== want.inside_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch\n  exp %p\n  got %p", want, out_data);
          end
        end
      end
      // accept after the check: a result on this edge is for an older word
      if (got_word) begin
        took = 1'b1;
        band_exp_q = {band_exp_q, band_predict(in_data)};
      end
      if (cfg_we) begin
        if (cfg_index == CFG_S_LIMIT) s_lim = cfg_wdata;
        else kind = cfg_wdata[2:0];
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      stall_cnt <= took ? 0 : stall_cnt + 1;
    end
    accepted_last <= got_word;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic in_t mk_word(logic [1:0] op, logic [TW-1:0] t,
                                  logic [SW-1:0] lo, logic [SW-1:0] up, logic [SW-1:0] qs);
    in_t w;
    w.operation  = op;
    w.point_time = t;
    w.lower_s_in = lo;
    w.upper_s_in = up;
    w.query_s    = qs;
    return w;
  endfunction

  function automatic void put_word(in_t w);
    word_q = {word_q, w};
  endfunction

  function automatic logic [SW-1:0] rnd32();
    return $urandom;
  endfunction

  // clear, load a band of npts points, then query it
  task automatic load_band(int npts);
    logic [TW-1:0]        tt[$];
    logic signed [SW-1:0] ll[$];
    logic [TW-1:0]        t, qt;
    longint               tcur, lo, up;
    int                   shft, i, nq, k, pick;
    logic signed [SW-1:0] qs;
    shft = $urandom_range(2, 24);
    tcur = ($urandom_range(3) == 0) ? longint'($urandom & 32'h7FFF_FFFF) >> 2
                                    : longint'($urandom_range(1 << 20));
    put_word(mk_word(OP_CLEAR, TW'($urandom), rnd32(), rnd32(), rnd32()));
    for (i = 0; i < npts; i++) begin
      if ($urandom_range(19) == 0) t = TW'($urandom);     // out of order / wild
      else begin
        tcur += ($urandom_range(9) == 0) ? 0 : $urandom_range(1 << shft);
        if (tcur > 64'h7FFF_FFFF) tcur = 64'h7FFF_FFFF;
        t = TW'(tcur);
      end
      if ($urandom_range(9) == 0) begin
        lo = longint'($signed(rnd32())); up = longint'($signed(rnd32()));
      end else begin
        lo = longint'($signed(rnd32())) >>> $urandom_range(8, 16);
        up = lo + $urandom_range(1 << 22);
      end
      tt = {tt, t};
      ll = {ll, SW'(lo)};
      put_word(mk_word(OP_APPEND, t, SW'(lo), SW'(up), rnd32()));
    end
    nq = $urandom_range(3, 12);
    for (k = 0; k < nq; k++) begin
      pick = $urandom_range(npts - 1);
      case ($urandom_range(9))
        0: qt = tt[pick];
        1: qt = TW'($urandom);
        2: qt = tt[0] - 1;
        3: qt = tt[npts-1] + 1;
        default: qt = TW'((longint'(tt[pick]) +
                           longint'(tt[(pick + 1) % npts])) / 2 + $urandom_range(3));
      endcase
      qs = ($urandom_range(4) == 0) ? rnd32() : ll[pick] + $signed($urandom_range(1 << 22));
      put_word(mk_word(OP_QUERY, qt, rnd32(), rnd32(), qs));
    end
  endtask

  task automatic drain();
    while (word_q.size() > 0 || start || band_exp_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [TW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int p, n0, npts;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_S_LIMIT;
    cfg_wdata = '0;
    band_cnt = 0;
    s_lim = 31'h7FFF_FFFF;
    kind = KIND_OTHER;
    sender_idle_pct = 12;
    accepted_last = 1'b0;
    stall_cnt = 0;
    mismatches = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, extremes, equal times, edges of the span, unused op
    put_word(mk_word(OP_QUERY, 31'd5, '0, '0, '0));
    put_word(mk_word(OP_NONE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    put_word(mk_word(OP_APPEND, 31'd0, 32'h8000_0000, 32'h7FFF_FFFF, '0));
    put_word(mk_word(OP_APPEND, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0));
    put_word(mk_word(OP_QUERY, 31'd0, '0, '0, '0));
    put_word(mk_word(OP_QUERY, 31'h7FFF_FFFF, '0, '0, 32'h8000_0000));
    put_word(mk_word(OP_QUERY, 31'h4000_0000, '0, '0, '0));
    put_word(mk_word(OP_QUERY, 31'h4000_0000, '0, '0, 32'h7FFF_FFFF));
    put_word(mk_word(OP_CLEAR, '0, '0, '0, '0));
    put_word(mk_word(OP_APPEND, 31'h100, 32'h1_0000, 32'h5_0000, '0));
    put_word(mk_word(OP_APPEND, 31'h100, 32'h2_0000, 32'h6_0000, '0));
    put_word(mk_word(OP_APPEND, 31'h300, 32'h3_0000, 32'h4_0000, '0));
    put_word(mk_word(OP_QUERY, 31'h100, '0, '0, 32'h3_0000));
    put_word(mk_word(OP_QUERY, 31'h200, '0, '0, 32'h3_0000));
    put_word(mk_word(OP_QUERY, 31'h200, '0, '0, 32'h1_0000));
    put_word(mk_word(OP_QUERY, 31'h300, '0, '0, '0));
    put_word(mk_word(OP_QUERY, 31'hFF, '0, '0, '0));
    put_word(mk_word(OP_QUERY, 31'h301, '0, '0, '0));
    put_word(mk_word(OP_APPEND, 31'h50, 32'hFFFF_0000, 32'h1000_0000, '0)); // out of order
    put_word(mk_word(OP_QUERY, 31'h80, '0, '0, '0));
    drain();

    for (p = 0; p < N_PHASES; p++) begin
      // idle profile: light, heavy, then none
      sender_idle_pct = (p < 3) ? 12 : ((p < 6) ? 67 : 0);
      cfg_write(CFG_S_LIMIT, (p == 0) ? 31'h7FFF_FFFF : (p == 1) ? 31'd0 :
                             TW'(p[0] ? $urandom : $urandom_range(1 << 24)));
      cfg_write(CFG_KIND, TW'($urandom ^ p));  // random value in every bit
      // low bits step through every kind over the phases
      cfg_write(CFG_KIND, TW'(31'(p) | ($urandom & 31'h7FFF_FFF8)));
      n0 = word_q.size();
      while (word_q.size() - n0 < PHASE_WORDS) begin
        case ($urandom_range(9))
          0: put_word(mk_word(2'($urandom), TW'($urandom), rnd32(), rnd32(), rnd32()));
          1: load_band(TBL_DEPTH + $urandom_range(1, 3));  // overfill
          default: begin
            npts = $urandom_range(1, 10);
            load_band(npts);
          end
        endcase
      end
      drain();  // sender holds off until every result has come back
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bsrq_pkg.sv
hdl/bsrq_ram.sv
hdl/bsrq_div.sv
hdl/bsrq_mul.sv
hdl/st_boundary_range_query.sv
tb/testbench.sv
